FILE: hdl/fvwf_pkg.sv
// package: sizes, controller-to-mac struct and coefficient rom of the window filter
package fvwf_pkg;

    localparam int TAPS           = 61;
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 17;

    // rom is stored as the first half of a symmetric q1.17 response
    localparam int ROM_TAPS = 61;
    localparam int ROM_FRAC = 17;
    localparam int ROM_HALF = (ROM_TAPS + 1) / 2;

    localparam int COEF_BITS = COEF_FRAC_BITS + 1;
    localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS  = PROD_BITS + $clog2(TAPS);
    localparam int K_BITS    = $clog2(TAPS);
    localparam int ADDR_BITS = $clog2(TAPS);
    localparam int FILL_BITS = $clog2(TAPS + 1);

    localparam int COEF_HALF [ROM_HALF] = '{
        0, 0, -2, 7, -16, 30, -50, 78, -114, 160, -218, 288, -371, 468,
        -580, 705, -844, 994, -1155, 1322, -1494, 1667, -1836, 1998,
        -2149, 2284, -2401, 2495, -2565, 2607, 128451
    };

    // controller to mac unit
    typedef struct packed {
        logic              clear;
        logic              issue;
        logic [K_BITS-1:0] k;
    } t_mac_ctl;

    // coefficient of tap k, rescaled to the configured fraction width
    function automatic logic signed [COEF_BITS-1:0] coef_at(input logic [K_BITS-1:0] k);
        int idx;
        int c;
        int m;
        int r;
        int s;
        idx = 0;
        c   = 0;
        m   = 0;
        r   = 0;
        s   = 0;
        if (int'(k) >= ROM_TAPS) begin
            return '0;
        end
        idx = (int'(k) < ROM_HALF) ? int'(k) : (ROM_TAPS - 1) - int'(k);
        c   = COEF_HALF[idx];
        if (COEF_FRAC_BITS >= ROM_FRAC) begin
            r = c <<< (COEF_FRAC_BITS - ROM_FRAC);
        end else begin
            s = ROM_FRAC - COEF_FRAC_BITS;
            m = (c < 0) ? -c : c;
            r = (m + (1 <<< (s - 1))) >>> s;
            r = (c < 0) ? -r : r;
        end
        return COEF_BITS'(r);
    endfunction

endpackage

FILE: hdl/fvwf_in_if.sv
// input sample channel: valid, ready and sample payload
interface fvwf_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [fvwf_pkg::SAMPLE_BITS-1:0]  sample;
    logic                                     block_start;

    modport source (output valid, output sample, output block_start, input ready);
    modport sink   (input valid, input sample, input block_start, output ready);
endinterface

FILE: hdl/fvwf_out_if.sv
// result channel: valid, ready and filter output payload
interface fvwf_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [fvwf_pkg::SAMPLE_BITS-1:0]  filtered;
    logic                                     clipped;

    modport source (output valid, output filtered, output clipped, input ready);
    modport sink   (input valid, input filtered, input clipped, output ready);
endinterface

FILE: hdl/fir_valid_window_filter.sv
// top level: window memory, tap sequencer and output register of the fir filter
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+------------------------------------
//  i_smp    | in  | valid/ready  | sample (s16), block_start (1)
//  o_res    | out | valid/ready  | filtered (s16), clipped (1)
//
// a sample is taken only while idle; once the block holds TAPS samples, each new
// sample runs TAPS taps through the single multiply-accumulate unit, then the
// read, product and accumulate stages drain before the result is loaded.
// the window lives in a circular ram, so one read per tap sets the pace.
// no clearing pass: no result is made before TAPS samples have been written.
// a finished result waits in the output register while the next sample is taken.
module fir_valid_window_filter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fvwf_in_if.sink           i_smp,
    fvwf_out_if.source        o_res
);

    localparam int TAPS = fvwf_pkg::TAPS;
    localparam int AW   = fvwf_pkg::ADDR_BITS;
    localparam int KW   = fvwf_pkg::K_BITS;
    localparam int FW   = fvwf_pkg::FILL_BITS;
    localparam int SB   = fvwf_pkg::SAMPLE_BITS;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic [AW-1:0]          r_wp, n_wp;
    logic [AW-1:0]          r_rd_addr, n_rd_addr;
    logic [KW-1:0]          r_k, n_k;
    logic [FW-1:0]          r_fill, n_fill;
    logic                   r_out_vld, n_out_vld;
    logic signed [SB-1:0]   r_filtered;
    logic                   r_clipped;

    logic                   w_accept;
    logic                   w_load;
    fvwf_pkg::t_mac_ctl     w_ctl;
    logic [SB-1:0]          w_rd_data;
    logic                   w_busy;
    logic signed [SB-1:0]   w_filtered;
    logic                   w_clipped;

    assign i_smp.ready = (r_state == ST_IDLE);
    assign w_accept    = i_smp.valid & i_smp.ready;
    assign w_load      = (r_state == ST_DRAIN) & ~w_busy & (~r_out_vld | o_res.ready);

    // sample window as a circular buffer
    fvwf_ram #(
        .WIDTH (SB),
        .DEPTH (TAPS)
    ) u_window (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept),
        .i_wr_addr (r_wp),
        .i_wr_data (i_smp.sample),
        .i_rd_en   (r_state == ST_RUN),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // shared multiply-accumulate unit
    assign w_ctl.clear = w_accept;
    assign w_ctl.issue = (r_state == ST_RUN);
    assign w_ctl.k     = r_k;

    fvwf_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_rd_data  (w_rd_data),
        .o_busy     (w_busy),
        .o_filtered (w_filtered),
        .o_clipped  (w_clipped)
    );

    // tap sequencer and block fill count
    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_rd_addr = r_rd_addr;
        n_k       = r_k;
        n_fill    = r_fill;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_wp      = (r_wp == AW'(TAPS - 1)) ? '0 : r_wp + AW'(1);
                    n_rd_addr = r_wp;
                    n_k       = '0;
                    if (i_smp.block_start) begin
                        n_fill = FW'(1);
                    end else if (r_fill < FW'(TAPS)) begin
                        n_fill = r_fill + FW'(1);
                    end
                    if (n_fill == FW'(TAPS)) begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                n_rd_addr = (r_rd_addr == '0) ? AW'(TAPS - 1) : r_rd_addr - AW'(1);
                n_k       = r_k + KW'(1);
                if (r_k == KW'(TAPS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register occupancy
    always_comb begin
        n_out_vld = r_out_vld;
        if (o_res.ready) begin
            n_out_vld = 1'b0;
        end
        if (w_load) begin
            n_out_vld = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wp      <= '0;
            r_fill    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_fill    <= n_fill;
            r_out_vld <= n_out_vld;
        end
    end

    // sequencer address and tap index
    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_k       <= n_k;
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_filtered <= w_filtered;
            r_clipped  <= w_clipped;
        end
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.filtered = r_filtered;
    assign o_res.clipped  = r_clipped;

endmodule

FILE: hdl/fvwf_ram.sv
// generic single write port ram with registered read
module fvwf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/fvwf_mac.sv
// shared multiply-accumulate unit with rounding and saturation of the sum
module fvwf_mac (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  fvwf_pkg::t_mac_ctl                      i_ctl,
    input  logic [fvwf_pkg::SAMPLE_BITS-1:0]        i_rd_data,
    output logic                                    o_busy,
    output logic signed [fvwf_pkg::SAMPLE_BITS-1:0] o_filtered,
    output logic                                    o_clipped
);

    localparam int SB = fvwf_pkg::SAMPLE_BITS;
    localparam int AB = fvwf_pkg::ACC_BITS;
    localparam int FB = fvwf_pkg::COEF_FRAC_BITS;

    localparam logic signed [AB:0] RND_HALF = (AB + 1)'(1) <<< (FB - 1);
    localparam logic signed [AB:0] Y_HI     = ((AB + 1)'(1) <<< (SB - 1)) - (AB + 1)'(1);
    localparam logic signed [AB:0] Y_LO     = -((AB + 1)'(1) <<< (SB - 1));

    logic                                   r_s1_vld;
    logic [fvwf_pkg::K_BITS-1:0]            r_s1_k;
    logic                                   r_s2_vld;
    logic signed [fvwf_pkg::PROD_BITS-1:0]  r_prod;
    logic signed [AB-1:0]                   r_acc;

    logic signed [fvwf_pkg::COEF_BITS-1:0]  w_coef;
    logic signed [AB:0]                     w_rnd;
    logic signed [AB:0]                     w_y;

    // stage valids track the ram read and the multiplier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_ctl.issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    // tap index is registered alongside the ram read data
    always_ff @(posedge i_clk) begin
        r_s1_k <= i_ctl.k;
    end

    // coefficient lookup and product register
    assign w_coef = fvwf_pkg::coef_at(r_s1_k);

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_prod <= w_coef * $signed(i_rd_data);
        end
    end

    // accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_s2_vld) begin
            r_acc <= r_acc + AB'(r_prod);
        end
    end

    // round half up, then saturate to the sample range
    always_comb begin
        w_rnd      = (AB + 1)'(r_acc) + RND_HALF;
        w_y        = w_rnd >>> FB;
        o_clipped  = 1'b0;
        o_filtered = w_y[SB-1:0];
        if (w_y > Y_HI) begin
            o_filtered = Y_HI[SB-1:0];
            o_clipped  = 1'b1;
        end else if (w_y < Y_LO) begin
            o_filtered = Y_LO[SB-1:0];
            o_clipped  = 1'b1;
        end
    end

    assign o_busy = r_s1_vld | r_s2_vld;

endmodule

FILE: sim/tb_top.sv
// testbench: fir window filter checked against a cycle-free predictor
`timescale 1ns / 1ps

module tb_top;

    localparam int TAPS           = fvwf_pkg::TAPS;
    localparam int COEF_FRAC_BITS = fvwf_pkg::COEF_FRAC_BITS;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 850;
    localparam int TAIL_ITEMS   = 200;
    localparam int SETTLE_CYCLES = 100;

    // symmetric q1.17 response, first half up to the center tap
    localparam int TAP_WEIGHT [31] = '{
        0, 0, -2, 7, -16, 30, -50, 78, -114, 160, -218, 288, -371, 468,
        -580, 705, -844, 994, -1155, 1322, -1494, 1667, -1836, 1998,
        -2149, 2284, -2401, 2495, -2565, 2607, 128451
    };

    localparam logic signed [15:0] S_MAX = 16'sh7fff;
    localparam logic signed [15:0] S_MIN = -16'sh8000;

    // content of one random block
    typedef enum int {
        STYLE_FULL_RANGE,
        STYLE_SMALL,
        STYLE_EXTREME,
        STYLE_PEAK,
        STYLE_CONSTANT
    } t_block_style;

    typedef struct packed {
        logic signed [15:0] filtered;
        logic               clipped;
    } t_filter_out;

    logic i_clk;
    logic i_rst_n;

    fvwf_in_if  smp_if ();
    fvwf_out_if res_if ();

    fir_valid_window_filter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if.sink),
        .o_res   (res_if.source)
    );

    // predictor state
    logic signed [15:0] sample_line [TAPS];
    int                 block_count;
    t_filter_out        due_outputs [$];

    int err_count;
    int cycle_count;
    bit no_idle;
    int hold_len;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // coefficient of tap k, mirrored about the center
    function automatic longint tap_coef(input int k);
        int idx;
        idx = (k <= 30) ? k : (TAPS - 1) - k;
        return longint'(TAP_WEIGHT[idx]);
    endfunction

    // shift one sample into the window and queue the filter output it yields
    function automatic void filter_window_step(input logic signed [15:0] x, input logic bs);
        longint      acc;
        longint      y;
        t_filter_out r;
        int          i;
        for (i = TAPS - 1; i > 0; i--) begin
            sample_line[i] = sample_line[i - 1];
        end
        sample_line[0] = x;
        if (bs) begin
            block_count = 1;
        end else if (block_count < TAPS) begin
            block_count++;
        end
        if (block_count < TAPS) begin
            return;
        end
        acc = 0;
        for (i = 0; i < TAPS; i++) begin
            acc += tap_coef(i) * longint'(sample_line[i]);
        end
        // round half up, floor shift by the fraction width
        y = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        r.clipped = 1'b0;
        if (y > 32767) begin
            y = 32767;
            r.clipped = 1'b1;
        end
        if (y < -32768) begin
            y = -32768;
            r.clipped = 1'b1;
        end
        r.filtered = 16'(y);
        due_outputs.push_back(r);
    endfunction

    // sign that maximizes the sum at window position k
    function automatic logic peak_positive(input int k);
        return (k % 2 == 1) || (k == 30);
    endfunction

    // offer one sample until it is taken, with random gaps before it
    task automatic send_sample(input logic signed [15:0] s, input logic bs);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
        end
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid       <= 1'b1;
        smp_if.sample      <= s;
        smp_if.block_start <= bs;
        do @(posedge i_clk); while (!smp_if.ready);
        filter_window_step(s, bs);
    endtask

    // stop offering and wait until every queued output has arrived
    task automatic wait_drain();
        smp_if.valid <= 1'b0;
        while (due_outputs.size() != 0) @(posedge i_clk);
    endtask

    // 61 samples that leave the window aligned with the coefficient signs
    task automatic send_peak(input logic signed [15:0] amp, input logic bs);
        int j;
        logic signed [15:0] s;
        for (j = 0; j < TAPS; j++) begin
            s = peak_positive(TAPS - 1 - j) ? amp : -amp;
            send_sample(s, bs && (j == 0));
        end
    endtask

    function automatic logic signed [15:0] pick_sample(input t_block_style style,
                                                       input int pos,
                                                       input logic signed [15:0] level);
        case (style)
            STYLE_FULL_RANGE: return 16'($urandom_range(0, 65535));
            STYLE_SMALL:      return 16'($signed($urandom_range(0, 600)) - 300);
            STYLE_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       return S_MAX;
                    1:       return S_MIN;
                    2:       return 16'sh0000;
                    default: return -16'sh0001;
                endcase
            end
            STYLE_PEAK: begin
                return peak_positive((TAPS - 1) - (pos % TAPS)) ? level : -level;
            end
            default: return level;
        endcase
    endfunction

    // samples before any block start count as a block begun at reset
    task automatic test_reset_block();
        send_peak(S_MAX, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh1234, 1'b0);
    endtask

    // full-scale constants and the negative peak pattern
    task automatic test_extremes();
        int j;
        for (j = 0; j < TAPS; j++) send_sample(S_MAX, j == 0);
        for (j = 0; j < 20; j++) send_sample(S_MIN, 1'b0);
        send_peak(-S_MAX, 1'b1);
        send_peak(S_MIN, 1'b0);
        send_sample(-16'sh0001, 1'b0);
    endtask

    // block start mid-stream, back to back, then a fresh fill
    task automatic test_block_restart();
        int j;
        for (j = 0; j < 10; j++) send_sample(16'($urandom_range(0, 65535)), 1'b0);
        send_sample(16'sh0100, 1'b1);
        send_sample(16'sh0200, 1'b1);
        send_sample(16'sh0300, 1'b1);
        for (j = 1; j < TAPS + 3; j++) begin
            send_sample(16'($urandom_range(0, 65535)), 1'b0);
        end
    endtask

    // long receiver hold-off while samples keep coming
    task automatic test_backpressure();
        int j;
        for (j = 0; j < TAPS; j++) send_sample(16'($urandom_range(0, 65535)), j == 0);
        hold_len = 600;
        for (j = 0; j < 25; j++) send_sample(16'($urandom_range(0, 65535)), 1'b0);
        wait_drain();
    endtask

    // sender pauses until everything has come out, then resumes the block
    task automatic test_drain_pause();
        int j;
        for (j = 0; j < 5; j++) send_sample(16'($urandom_range(0, 65535)), 1'b0);
        wait_drain();
        for (j = 0; j < 5; j++) send_sample(16'($urandom_range(0, 65535)), 1'b0);
    endtask

    // mostly whole blocks with random content, some short blocks and noise
    task automatic run_blocks(input int n_items);
        int           sent;
        int           len;
        int           j;
        int           kind;
        t_block_style style;
        logic signed [15:0] level;
        sent = 0;
        while (sent < n_items) begin
            kind  = $urandom_range(0, 99);
            style = t_block_style'($urandom_range(0, 4));
            level = 16'($urandom_range(0, 65535));
            if (style == STYLE_PEAK && $urandom_range(0, 1) == 0) begin
                level = $urandom_range(0, 1) ? S_MAX : S_MIN;
            end
            if (kind < 80) begin
                len = TAPS + $urandom_range(0, 80);
                for (j = 0; j < len; j++) begin
                    send_sample(pick_sample(style, j, level), j == 0);
                end
            end else if (kind < 90) begin
                len = $urandom_range(1, TAPS - 1);
                for (j = 0; j < len; j++) begin
                    send_sample(pick_sample(style, j, level), j == 0);
                end
            end else begin
                len = $urandom_range(5, 60);
                for (j = 0; j < len; j++) begin
                    send_sample(pick_sample(style, j, level), $urandom_range(0, 19) == 0);
                end
            end
            sent += len;
        end
    endtask

    // receiver: random stall bursts and the requested long hold-off
    initial begin
        res_if.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_len > 0) begin
                res_if.ready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // compare each output transaction with the oldest prediction
    always @(posedge i_clk) begin : check_outputs
        t_filter_out want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (due_outputs.size() == 0) begin
                $display("%0t: unexpected output, expected none, actual %0d/%0b",
                         $time, res_if.filtered, res_if.clipped);
                err_count++;
            end else begin
                want = due_outputs.pop_front();
                if (res_if.filtered !== want.filtered || res_if.clipped !== want.clipped) begin
                    $display("%0t: mismatch, expected %0d/%0b, actual %0d/%0b",
                             $time, want.filtered, want.clipped,
                             res_if.filtered, res_if.clipped);
                    err_count++;
                end
            end
        end
    end

    // main sequence
    initial begin
        int j;
        err_count   = 0;
        cycle_count = 0;
        no_idle     = 1'b0;
        hold_len    = 0;
        block_count = 0;
        for (j = 0; j < TAPS; j++) sample_line[j] = '0;
        i_rst_n            <= 1'b0;
        smp_if.valid       <= 1'b0;
        smp_if.sample      <= '0;
        smp_if.block_start <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_block();
        test_extremes();
        test_block_restart();
        test_backpressure();
        test_drain_pause();
        run_blocks(RANDOM_ITEMS);
        no_idle = 1'b1;
        run_blocks(TAIL_ITEMS);

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
